@@ rtl/cla_pkg.sv @@
// Shared types, constants and codes for the command line assembler.
package cla_pkg;

  localparam int LEN_W         = 13;
  localparam int IDLE_W        = 16;
  localparam int BYTE_W        = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int MAX_LINE_LIMIT_DEFAULT = 4096;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] CH_LF         = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR         = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_DEL        = 8'h7F;

  localparam logic [LEN_W-1:0]  MAX_LINE_LEN_RESET = 13'd1024;
  localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET   = 16'd900;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_LINE_LEN = 2'd0,
    REG_IDLE_LIMIT   = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_LINE_END = 2'd1,
    KIND_TOO_LONG = 2'd2,
    KIND_TIMEOUT  = 2'd3
  } kind_t;

  typedef enum logic {
    MODE_BYTE = 1'b0,
    MODE_TICK = 1'b1
  } mode_t;

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] out_byte;
    logic [LEN_W-1:0]  line_length;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

endpackage

@@ rtl/cla_core.sv @@
// Line framing state, configuration registers and per-item result logic.
module cla_core import cla_pkg::*; #(
  parameter int MAX_LINE_LIMIT = MAX_LINE_LIMIT_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  in_item_t              item,
  output push_t                 push
);

  logic [LEN_W-1:0]  max_line_len;
  logic [IDLE_W-1:0] idle_limit;
  logic [LEN_W-1:0]  line_position, line_position_next;
  logic              held_return, held_return_next;
  logic [IDLE_W-1:0] idle_count, idle_count_next;
  logic              halted, halted_next;

  logic [LEN_W-1:0]  eff_limit;
  logic [LEN_W:0]    pos_plus;
  logic [IDLE_W-1:0] idle_lim;
  logic [LEN_W-1:0]  len;
  logic              ctrl;
  logic [BYTE_W-1:0] clean;

  function automatic out_item_t make_res(kind_t k, logic [BYTE_W-1:0] b, logic [LEN_W-1:0] l);
    out_item_t r;
    r.kind        = k;
    r.out_byte    = b;
    r.line_length = l;
    r.last        = 1'b0;
    return r;
  endfunction

  assign eff_limit = (32'(max_line_len) > MAX_LINE_LIMIT) ? LEN_W'(MAX_LINE_LIMIT)
                                                          : max_line_len;
  assign pos_plus  = {1'b0, line_position} + 1'b1;
  assign idle_lim  = (idle_limit == '0) ? IDLE_W'(1) : idle_limit;
  assign len       = (held_return && line_position != '0) ? line_position - 1'b1
                                                          : line_position;
  assign ctrl      = (item.in_byte == CH_DEL) || ((item.in_byte & 8'h60) == 8'h00);
  assign clean     = ctrl ? CH_UNDERSCORE : item.in_byte;

  always_comb begin
    line_position_next = line_position;
    held_return_next   = held_return;
    idle_count_next    = idle_count;
    halted_next        = halted;
    push.count         = 2'd0;
    push.first         = make_res(KIND_DATA, '0, '0);
    push.second        = make_res(KIND_DATA, '0, '0);
    if (accept && !halted) begin
      if (item.mode == MODE_TICK) begin
        if (idle_count != '1) begin
          idle_count_next = idle_count + 1'b1;
        end
        if (idle_count_next >= idle_lim) begin
          halted_next = 1'b1;
          push.count  = 2'd1;
          push.first  = make_res(KIND_TIMEOUT, '0, '0);
        end
      end else begin
        idle_count_next = '0;
        if (item.in_byte == CH_LF) begin
          held_return_next   = 1'b0;
          line_position_next = '0;
          push.count         = 2'd1;
          push.first         = make_res(KIND_LINE_END, '0, len);
        end else if (pos_plus >= {1'b0, eff_limit}) begin
          halted_next      = 1'b1;
          held_return_next = 1'b0;
          push.count       = 2'd1;
          push.first       = make_res(KIND_TOO_LONG, '0, '0);
        end else begin
          line_position_next = pos_plus[LEN_W-1:0];
          held_return_next   = (item.in_byte == CH_CR);
          if (held_return) begin
            push.first = make_res(KIND_DATA, CH_UNDERSCORE, '0);
            if (item.in_byte == CH_CR) begin
              push.count = 2'd1;
            end else begin
              push.count  = 2'd2;
              push.second = make_res(KIND_DATA, clean, '0);
            end
          end else if (item.in_byte != CH_CR) begin
            push.count = 2'd1;
            push.first = make_res(KIND_DATA, clean, '0);
          end
        end
      end
    end
    if (push.count == 2'd1) begin
      push.first.last = 1'b1;
    end
    if (push.count == 2'd2) begin
      push.second.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_len  <= MAX_LINE_LEN_RESET;
      idle_limit    <= IDLE_LIMIT_RESET;
      line_position <= '0;
      held_return   <= 1'b0;
      idle_count    <= '0;
      halted        <= 1'b0;
    end else begin
      if (cfg_write && cfg_index == REG_MAX_LINE_LEN) begin
        max_line_len <= cfg_data[LEN_W-1:0];
      end
      if (cfg_write && cfg_index == REG_IDLE_LIMIT) begin
        idle_limit <= cfg_data[IDLE_W-1:0];
      end
      line_position <= line_position_next;
      held_return   <= held_return_next;
      idle_count    <= idle_count_next;
      halted        <= halted_next;
    end
  end

endmodule

@@ rtl/cla_queue.sv @@
// Result queue: takes up to two items per cycle, hands out one if ready.
module cla_queue import cla_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  push_t     push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  out_item_t               entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QUEUE_CNT_W-1:0]  count;
  logic                    pop;
  logic [QUEUE_PTR_W-1:0]  wr_ptr_1;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_item  = entries[rd_ptr];
  assign room      = (count <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
  assign wr_ptr_1  = wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QUEUE_PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
    end
  end

endmodule

@@ rtl/command_line_assembler_top.sv @@
// Top level of the command line assembler.
// One input item is accepted per cycle whenever the four-entry result queue has room for
// two results; a byte or tick is decoded and the line state updated in the cycle of
// acceptance, and its zero, one or two results enter the queue, which delivers one item
// per cycle while out_ready is high. One item per cycle is sustained while items give at
// most one result each; a held carriage return followed by a byte other than CR or LF
// yields two. After a too-long or timeout error the block drops all items until reset.
module command_line_assembler_top import cla_pkg::*; #(
  parameter int MAX_LINE_LIMIT = MAX_LINE_LIMIT_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item
);

  push_t push;
  logic  accept;

  assign accept = in_valid && in_ready;

  cla_core #(
    .MAX_LINE_LIMIT(MAX_LINE_LIMIT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (in_item),
    .push      (push)
  );

  cla_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
